// File: sv/mld_pkg.sv
package mld_pkg;

  localparam int NumChannels = 8;
  localparam int NumBands    = 5;
  localparam int RefLength   = 250;

  // The reference table has two entries per sample step, so a whole turn is 2*RefLength.
  localparam int RefFull    = 2 * RefLength;
  localparam int RefQuarter = RefFull / 4;

  localparam int ChanW   = 3;
  localparam int SampleW = 24;
  localparam int CoefW   = 16;
  localparam int AccW    = 32;
  localparam int AmpW    = 25;
  localparam int PhW     = 16;
  localparam int RefW    = 16;
  localparam int CfgIdxW = 3;

  localparam int BandW = $clog2(NumBands);
  localparam int AddrW = $clog2(NumChannels * NumBands);
  localparam int Depth = NumChannels * NumBands;
  localparam int PosW  = $clog2(RefLength);
  localparam int MW    = $clog2(RefFull);
  localparam int JW    = $clog2(RefQuarter);

  localparam int InW  = ((ChanW + SampleW + 7) / 8) * 8;
  localparam int OutW = ((ChanW + NumBands * (AmpW + PhW) + 7) / 8) * 8;

  localparam int MulW    = 33;
  localparam int ProdW   = 2 * MulW;
  localparam int DiffW   = 41;
  localparam int SumW    = 64;
  localparam int RootW   = 32;
  localparam int RemW    = 36;
  localparam int CordicW = 60;
  localparam int CordicSteps = 30;
  localparam int SqrtSteps   = 32;
  localparam int StepW       = 5;

  localparam logic [AmpW-1:0] AmpMax = '1;

  localparam logic [MW-1:0] BandFreq2 [NumBands] = '{9'd5, 9'd12, 9'd20, 9'd40, 9'd80};
  localparam logic [CoefW-1:0] CoefReset [NumBands] =
    '{16'd60776, 16'd60776, 16'd60776, 16'd50972, 16'd39644};

  // Arc tangent of 2^-k, with a whole turn equal to 2^32.
  localparam logic [31:0] AtanTurn [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] TaylorDen [6] =
    '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef logic [RefW-2:0] qrom_t [RefQuarter];

  // Magnitude of the sine over one quarter wave. The odd quadrants run the angle
  // backward from the quarter point, which rounds differently, so they get a table of their own.
  function automatic qrom_t build_qrom(input logic odd);
    qrom_t rom;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int j = 0; j < RefQuarter; j++) begin
      r = (64'(j) << 32) / RefFull;
      if (odd) r = Q30One - r;
      x  = (r * HalfPiQ30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30One;
      for (int k = 0; k < 6; k++) t = Q30One - ((x2 * t) >> 30) / TaylorDen[k];
      s = (x * t) >> 30;
      v = (s + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      rom[j] = v[RefW-2:0];
    end
    return rom;
  endfunction

  localparam qrom_t SinEven = build_qrom(1'b0);
  localparam qrom_t SinOdd  = build_qrom(1'b1);

  typedef enum logic [3:0] {
    OpNone, OpStart, OpRead, OpRef, OpMulP, OpDiff, OpMulLo, OpAddLo,
    OpAddHi, OpClamp, OpSqI, OpSqQ, OpSum, OpIter, OpStore, OpFinish
  } mld_op_e;

  typedef struct packed {
    mld_op_e          op;
    logic             sel;
    logic [BandW-1:0] band;
  } mld_cmd_t;

  typedef struct packed {
    logic iter_busy;
    logic out_free;
  } mld_stat_t;

endpackage

// File: sv/multiband_lockin_demodulator.sv
// Five-band lock-in demodulator for eight ADC channels. Each request carries one signed
// sample and its channel; the block mixes it with the cosine and sine of each band's
// reference, low-pass filters I and Q per channel and band, and returns one result with
// amplitude and phase for all five bands. A request is taken, then each band is worked in
// turn on the shared 33x33 multiplier and adder and waits for the 32-step bit-serial
// square root, with the 30-step CORDIC for the phase running alongside it, and then the
// result is handed over. The hand-over waits while the previous result is still held at
// the output. A new request is taken while the previous result still waits at the output.
// The filter coefficients may be written only while no request is in progress.
module multiband_lockin_demodulator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // chan [2:0], sample [26:3], zero fill above
  input  logic [mld_pkg::InW-1:0]     s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // chan_out, amp_delta, amp_theta, amp_alpha, amp_beta, amp_gamma,
  // ph_delta, ph_theta, ph_alpha, ph_beta, ph_gamma
  output logic [mld_pkg::OutW-1:0]    m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [mld_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mld_pkg::CoefW-1:0]   cfg_data_i
);
  import mld_pkg::*;

  mld_cmd_t   cmd;
  mld_stat_t  stat;
  logic [ChanW-1:0] out_chan;
  logic [AmpW-1:0]  out_amp [NumBands];
  logic [PhW-1:0]   out_ph [NumBands];

  mld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mld_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .chan_i      (s_axis_tdata[ChanW-1:0]),
    .sample_i    ($signed(s_axis_tdata[ChanW +: SampleW])),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_chan_o  (out_chan),
    .out_amp_o   (out_amp),
    .out_ph_o    (out_ph)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[ChanW-1:0] = out_chan;
    for (int b = 0; b < NumBands; b++) begin
      m_axis_tdata[ChanW + b * AmpW +: AmpW] = out_amp[b];
      m_axis_tdata[ChanW + NumBands * AmpW + b * PhW +: PhW] = out_ph[b];
    end
  end

endmodule

// File: sv/mld_isqrt.sv
module mld_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mld_pkg::SumW-1:0]   radicand_i,
  output logic                       busy_o,
  output logic [mld_pkg::RootW-1:0]  root_o
);
  import mld_pkg::*;

  logic              busy_q;
  logic [StepW-1:0]  cnt_q;
  logic [SumW-1:0]   val_q;
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [RemW-1:0]   rem_t;
  logic [RemW-1:0]   trial;

  // One result bit per cycle, restoring method.
  assign rem_t = {rem_q[RemW-3:0], val_q[SumW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == StepW'(SqrtSteps - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= val_q << 2;
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// File: sv/mld_cordic.sv
module mld_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [mld_pkg::AccW-1:0]  iv_i,
  input  logic signed [mld_pkg::AccW-1:0]  qv_i,
  output logic                             busy_o,
  output logic [mld_pkg::PhW-1:0]          phase_o
);
  import mld_pkg::*;

  logic                      busy_q;
  logic [StepW-1:0]          k_q;
  logic                      zero_q;
  logic signed [CordicW-1:0] x_q;
  logic signed [CordicW-1:0] y_q;
  logic [31:0]               ang_q;
  logic signed [CordicW-1:0] xi;
  logic signed [CordicW-1:0] yi;
  logic signed [CordicW-1:0] xs;
  logic signed [CordicW-1:0] ys;
  logic                      y_pos;
  logic [31:0]               ang_r;

  assign xi    = CordicW'(iv_i) <<< 24;
  assign yi    = CordicW'(qv_i) <<< 24;
  assign xs    = x_q >>> k_q;
  assign ys    = y_q >>> k_q;
  assign y_pos = !y_q[CordicW-1] && (y_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (busy_q) begin
      k_q <= k_q + 1'b1;
      if (k_q == StepW'(CordicSteps - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (iv_i == '0) && (qv_i == '0);
      // A vector in the left half plane is turned by half a turn first.
      if (iv_i[AccW-1]) begin
        x_q   <= -xi;
        y_q   <= -yi;
        ang_q <= 32'h8000_0000;
      end else begin
        x_q   <= xi;
        y_q   <= yi;
        ang_q <= '0;
      end
    end else if (busy_q) begin
      if (y_pos) begin
        x_q   <= x_q + ys;
        y_q   <= y_q - xs;
        ang_q <= ang_q + AtanTurn[k_q];
      end else begin
        x_q   <= x_q - ys;
        y_q   <= y_q + xs;
        ang_q <= ang_q - AtanTurn[k_q];
      end
    end
  end

  assign ang_r   = ang_q + 32'h0000_8000;
  assign busy_o  = busy_q;
  assign phase_o = zero_q ? '0 : ang_r[31 -: PhW];

endmodule

// File: sv/mld_dp.sv
module mld_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mld_pkg::mld_cmd_t                  cmd_i,
  output mld_pkg::mld_stat_t                 stat_o,
  input  logic [mld_pkg::ChanW-1:0]          chan_i,
  input  logic signed [mld_pkg::SampleW-1:0] sample_i,
  input  logic                               cfg_we_i,
  input  logic [mld_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mld_pkg::CoefW-1:0]          cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mld_pkg::ChanW-1:0]          out_chan_o,
  output logic [mld_pkg::AmpW-1:0]           out_amp_o [mld_pkg::NumBands],
  output logic [mld_pkg::PhW-1:0]            out_ph_o [mld_pkg::NumBands]
);
  import mld_pkg::*;

  localparam int MemW = 2 * AccW + MW;

  logic [CoefW-1:0]         coef_q [NumBands];
  logic [PosW-1:0]          pos_q [NumChannels];
  logic                     vld_q [Depth];
  logic [MemW-1:0]          mem_q [Depth];
  logic [MemW-1:0]          rd_q;
  logic                     vld_rd_q;

  logic [ChanW-1:0]         chan_q;
  logic signed [SampleW-1:0] sample_q;
  logic signed [AccW-1:0]   acc_i_q;
  logic signed [AccW-1:0]   acc_q_q;
  logic signed [RefW-1:0]   cv_q;
  logic signed [RefW-1:0]   sv_q;
  logic [MW-1:0]            mnx_q;
  logic signed [ProdW-1:0]  mp_q;
  logic signed [DiffW-1:0]  d_q;
  logic signed [SumW-1:0]   s_q;
  logic [SumW-1:0]          sq_q;
  logic [AmpW-1:0]          amp_q [NumBands];
  logic [PhW-1:0]           ph_q [NumBands];

  logic                     out_vld_q;
  logic [ChanW-1:0]         out_chan_q;
  logic [AmpW-1:0]          out_amp_q [NumBands];
  logic [PhW-1:0]           out_ph_q [NumBands];

  logic [AddrW-1:0]         addr;
  logic [CoefW-1:0]         coef;
  logic signed [MulW-1:0]   ma;
  logic signed [MulW-1:0]   mb;
  logic [MW-1:0]            m_cur;
  logic [1:0]               quad;
  logic [JW-1:0]            jdx;
  logic [PosW-1:0]          n_cur;
  logic                     wrap;
  logic [MW:0]              msum;
  logic [MW-1:0]            m_next;
  logic signed [AccW-1:0]   acc_sel;
  logic signed [SumW-1:0]   s_shift;
  logic signed [AccW-1:0]   acc_new;
  logic                     iter_start;
  logic                     sqrt_busy;
  logic                     cordic_busy;
  logic [RootW-1:0]         root;
  logic [PhW-1:0]           phase;
  logic [RootW:0]           root_rnd;
  logic [RootW-7:0]         amp_full;
  logic [AmpW-1:0]          amp_sat;

  function automatic logic signed [RefW-1:0] ref_val(input logic [1:0] q,
                                                      input logic [JW-1:0] j);
    logic [RefW-1:0] mag;
    mag = {1'b0, (q[0] ? SinOdd[j] : SinEven[j])};
    return q[1] ? -$signed(mag) : $signed(mag);
  endfunction

  assign addr = AddrW'(int'(chan_q) * NumBands + int'(cmd_i.band));
  assign coef = coef_q[cmd_i.band];

  // This band's position for this sample as quadrant and offset, and the next position.
  always_comb begin
    m_cur = vld_rd_q ? rd_q[MW-1:0] : '0;
    if (m_cur >= MW'(3 * RefQuarter)) quad = 2'd3;
    else if (m_cur >= MW'(2 * RefQuarter)) quad = 2'd2;
    else if (m_cur >= MW'(RefQuarter)) quad = 2'd1;
    else quad = 2'd0;
    jdx   = JW'(m_cur - MW'(int'(quad) * RefQuarter));
    n_cur = pos_q[chan_q];
    wrap  = n_cur == PosW'(RefLength - 1);
    msum  = {1'b0, m_cur} + {1'b0, BandFreq2[cmd_i.band]};
    if (wrap) m_next = '0;
    else if (msum >= (MW + 1)'(RefFull)) m_next = MW'(msum - (MW + 1)'(RefFull));
    else m_next = msum[MW-1:0];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OpMulP: begin
        ma = MulW'(sample_q);
        mb = cmd_i.sel ? MulW'(sv_q) : MulW'(cv_q);
      end
      OpMulLo: begin
        ma = MulW'(coef);
        mb = MulW'(d_q[23:0]);
      end
      OpAddLo: begin
        ma = MulW'(coef);
        mb = MulW'($signed(d_q[DiffW-1:24]));
      end
      OpSqI: begin
        ma = MulW'(acc_i_q);
        mb = MulW'(acc_i_q);
      end
      OpSqQ: begin
        ma = MulW'(acc_q_q);
        mb = MulW'(acc_q_q);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign acc_sel = cmd_i.sel ? acc_q_q : acc_i_q;
  assign s_shift = s_q >>> 23;

  always_comb begin
    if (s_shift > SumW'(64'sh7FFF_FFFF)) acc_new = 32'sh7FFF_FFFF;
    else if (s_shift < -SumW'(64'sh8000_0000)) acc_new = 32'sh8000_0000;
    else acc_new = s_shift[AccW-1:0];
  end

  assign root_rnd = {1'b0, root} + (RootW + 1)'(64);
  assign amp_full = root_rnd[RootW:7];
  assign amp_sat  = (amp_full > (RootW - 6)'(AmpMax)) ? AmpMax : amp_full[AmpW-1:0];

  assign iter_start = cmd_i.op == OpIter;

  mld_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (iter_start),
    .radicand_i (sq_q),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  mld_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iter_start),
    .iv_i    (acc_i_q),
    .qv_i    (acc_q_q),
    .busy_o  (cordic_busy),
    .phase_o (phase)
  );

  // State memory: I, Q and the reference position of every channel and band.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpSum) mem_q[addr] <= {acc_i_q, acc_q_q, mnx_q};
    if (cmd_i.op == OpRead) rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBands; b++) coef_q[b] <= CoefReset[b];
      for (int c = 0; c < NumChannels; c++) pos_q[c] <= '0;
      for (int e = 0; e < Depth; e++) vld_q[e] <= 1'b0;
      vld_rd_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i && (int'(cfg_idx_i) < NumBands)) coef_q[cfg_idx_i] <= cfg_data_i;
      if (cmd_i.op == OpRead) vld_rd_q <= vld_q[addr];
      if (cmd_i.op == OpSum) vld_q[addr] <= 1'b1;
      if (cmd_i.op == OpFinish) begin
        out_vld_q     <= 1'b1;
        pos_q[chan_q] <= wrap ? '0 : n_cur + 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mp_q <= ma * mb;
    case (cmd_i.op)
      OpStart: begin
        chan_q   <= chan_i;
        sample_q <= sample_i;
      end
      OpRef: begin
        acc_i_q <= vld_rd_q ? $signed(rd_q[MemW-1 -: AccW]) : '0;
        acc_q_q <= vld_rd_q ? $signed(rd_q[MemW-AccW-1 -: AccW]) : '0;
        sv_q    <= ref_val(quad, jdx);
        cv_q    <= ref_val(quad + 2'd1, jdx);
        mnx_q   <= m_next;
      end
      OpDiff: begin
        d_q <= (DiffW'(acc_sel) <<< 7) - DiffW'($signed(mp_q[39:0]));
        s_q <= (SumW'($signed(mp_q[39:0])) <<< 16) + 64'sd4194304;
      end
      OpAddLo: s_q <= s_q + SumW'(mp_q);
      OpAddHi: s_q <= s_q + (SumW'(mp_q) <<< 24);
      OpClamp: begin
        if (cmd_i.sel) acc_q_q <= acc_new;
        else acc_i_q <= acc_new;
      end
      OpSqQ: sq_q <= SumW'(mp_q);
      OpSum: sq_q <= sq_q + SumW'(mp_q);
      OpStore: begin
        amp_q[cmd_i.band] <= amp_sat;
        ph_q[cmd_i.band]  <= phase;
      end
      OpFinish: begin
        out_chan_q <= chan_q;
        out_amp_q  <= amp_q;
        out_ph_q   <= ph_q;
      end
      default: ;
    endcase
  end

  assign stat_o.iter_busy = sqrt_busy || cordic_busy;
  assign stat_o.out_free  = !out_vld_q || out_ready_i;
  assign out_valid_o      = out_vld_q;
  assign out_chan_o       = out_chan_q;
  assign out_amp_o        = out_amp_q;
  assign out_ph_o         = out_ph_q;

endmodule

// File: sv/mld_ctrl.sv
module mld_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output mld_pkg::mld_cmd_t   cmd_o,
  input  mld_pkg::mld_stat_t  stat_i
);
  import mld_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRead  = 4'd1;
  localparam logic [3:0] SRef   = 4'd2;
  localparam logic [3:0] SMulP  = 4'd3;
  localparam logic [3:0] SDiff  = 4'd4;
  localparam logic [3:0] SMulLo = 4'd5;
  localparam logic [3:0] SAddLo = 4'd6;
  localparam logic [3:0] SAddHi = 4'd7;
  localparam logic [3:0] SClamp = 4'd8;
  localparam logic [3:0] SSqI   = 4'd9;
  localparam logic [3:0] SSqQ   = 4'd10;
  localparam logic [3:0] SSum   = 4'd11;
  localparam logic [3:0] SIter  = 4'd12;
  localparam logic [3:0] SWait  = 4'd13;
  localparam logic [3:0] SStore = 4'd14;
  localparam logic [3:0] SFin   = 4'd15;

  logic [3:0]       state_q, state_d;
  logic             sel_q, sel_d;
  logic [BandW-1:0] band_q, band_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    band_d  = band_q;
    cmd_o.op   = OpNone;
    cmd_o.sel  = sel_q;
    cmd_o.band = band_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OpStart;
          state_d  = SRead;
          band_d   = '0;
          sel_d    = 1'b0;
        end
      end
      SRead: begin
        cmd_o.op = OpRead;
        state_d  = SRef;
      end
      SRef: begin
        cmd_o.op = OpRef;
        state_d  = SMulP;
      end
      SMulP: begin
        cmd_o.op = OpMulP;
        state_d  = SDiff;
      end
      SDiff: begin
        cmd_o.op = OpDiff;
        state_d  = SMulLo;
      end
      SMulLo: begin
        cmd_o.op = OpMulLo;
        state_d  = SAddLo;
      end
      SAddLo: begin
        cmd_o.op = OpAddLo;
        state_d  = SAddHi;
      end
      SAddHi: begin
        cmd_o.op = OpAddHi;
        state_d  = SClamp;
      end
      SClamp: begin
        // The in-phase pass is followed by the quadrature pass.
        cmd_o.op = OpClamp;
        sel_d    = !sel_q;
        state_d  = sel_q ? SSqI : SMulP;
      end
      SSqI: begin
        cmd_o.op = OpSqI;
        state_d  = SSqQ;
      end
      SSqQ: begin
        cmd_o.op = OpSqQ;
        state_d  = SSum;
      end
      SSum: begin
        cmd_o.op = OpSum;
        state_d  = SIter;
      end
      SIter: begin
        cmd_o.op = OpIter;
        state_d  = SWait;
      end
      SWait: begin
        if (!stat_i.iter_busy) state_d = SStore;
      end
      SStore: begin
        cmd_o.op = OpStore;
        if (band_q == BandW'(NumBands - 1)) begin
          state_d = SFin;
        end else begin
          band_d  = band_q + 1'b1;
          state_d = SRead;
        end
      end
      SFin: begin
        if (stat_i.out_free) begin
          cmd_o.op = OpFinish;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      sel_q   <= 1'b0;
      band_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      band_q  <= band_d;
    end
  end

  assign in_ready_o = state_q == SIdle;

endmodule

// File: sv/mld_checker.sv
module mld_sva (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [mld_pkg::OutW-1:0] m_axis_tdata
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  // A new result only appears at the end of a request.
  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a request in progress");

endmodule

bind multiband_lockin_demodulator mld_sva u_mld_sva (.*);

// File: tb/sv/mld_checker.sv
`timescale 1ns / 1ps

module mld_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [mld_pkg::InW-1:0]     s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [mld_pkg::OutW-1:0]    m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [mld_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mld_pkg::CoefW-1:0]   cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          results_seen_o
);
  import mld_pkg::*;

  localparam int NumOut = 5;

  typedef struct {
    logic [ChanW-1:0] chan;
    logic [AmpW-1:0]  amp [NumOut];
    logic [PhW-1:0]   ph  [NumOut];
  } band_result_t;

  localparam logic [31:0] AtanStep [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };
  localparam int Freq2 [NumOut] = '{5, 12, 20, 40, 80};

  logic [15:0]        coef [NumOut];
  logic signed [31:0] acc_i [NumChannels][NumBands];
  logic signed [31:0] acc_q [NumChannels][NumBands];
  int                 pos [NumChannels];
  band_result_t       expected_q [$];
  int                 fails;
  int                 seen;

  assign fail_count_o   = fails;
  assign pending_o      = expected_q.size();
  assign results_seen_o = seen;

  function automatic logic signed [31:0] ref_sine(logic [31:0] ph);
    logic [1:0]  quad;
    logic [63:0] r, x, x2, t, s, v;
    int dens [6];
    dens = '{156, 110, 72, 42, 20, 6};
    quad = ph[31:30];
    r = {34'd0, ph[29:0]};
    if (quad[0]) r = 64'd1073741824 - r;
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    for (int k = 0; k < 6; k++) t = 64'd1073741824 - ((x2 * t) >> 30) / 64'(dens[k]);
    s = (x * t) >> 30;
    v = (s + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return quad[1] ? -$signed(32'(v)) : $signed(32'(v));
  endfunction

  function automatic logic signed [31:0] lowpass(logic signed [31:0] acc,
                                                 longint prod, logic [15:0] a);
    longint s;
    longint r;
    s = longint'(a) * longint'(acc) * 128 + longint'(65536 - int'(a)) * prod
        + (longint'(1) << 22);
    r = s >>> 23;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return 32'(r);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] vector_angle(logic signed [31:0] iv, logic signed [31:0] qv);
    longint x, y, nx;
    logic [31:0] ang;
    if (iv == 0 && qv == 0) return 16'd0;
    x = longint'(iv) * 16777216;
    y = longint'(qv) * 16777216;
    ang = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int k = 0; k < 30; k++) begin
      if (y > 0) begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        ang += AtanStep[k];
      end else begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        ang -= AtanStep[k];
      end
      x = nx;
    end
    ang = ang + 32'd32768;
    return ang[31:16];
  endfunction

  task automatic demodulate(logic [ChanW-1:0] ch, logic signed [23:0] smp);
    band_result_t res;
    logic [31:0] ph;
    logic signed [31:0] cv, sv, iv, qv;
    logic [63:0] mag;
    int m;
    if (int'(ch) >= NumChannels) return;
    res.chan = ch;
    for (int b = 0; b < NumOut; b++) begin
      res.amp[b] = '0;
      res.ph[b]  = '0;
    end
    for (int b = 0; b < ((NumBands < NumOut) ? NumBands : NumOut); b++) begin
      m  = (Freq2[b] * pos[ch]) % RefFull;
      ph = 32'((longint'(m) << 32) / RefFull);
      sv = ref_sine(ph);
      cv = ref_sine(ph + 32'h4000_0000);
      iv = lowpass(acc_i[ch][b], longint'(smp) * longint'(cv), coef[b]);
      qv = lowpass(acc_q[ch][b], longint'(smp) * longint'(sv), coef[b]);
      acc_i[ch][b] = iv;
      acc_q[ch][b] = qv;
      mag = (root_floor(64'(longint'(iv) * iv) + 64'(longint'(qv) * qv)) + 64'd64) >> 7;
      res.amp[b] = (mag > 64'(AmpMax)) ? AmpMax : mag[AmpW-1:0];
      res.ph[b]  = vector_angle(iv, qv);
    end
    pos[ch] = (pos[ch] + 1 >= RefLength) ? 0 : pos[ch] + 1;
    expected_q.push_back(res);
  endtask

  task automatic compare_result(logic [OutW-1:0] d);
    band_result_t e;
    logic [AmpW-1:0] a;
    logic [PhW-1:0]  p;
    seen++;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: %h", d);
      fails++;
      return;
    end
    e = expected_q.pop_front();
    if (d[ChanW-1:0] !== e.chan) begin
      $error("chan_out expected %0d actual %0d", e.chan, d[ChanW-1:0]);
      fails++;
    end
    for (int b = 0; b < NumOut; b++) begin
      a = d[ChanW + b*AmpW +: AmpW];
      p = d[ChanW + NumOut*AmpW + b*PhW +: PhW];
      if (a !== e.amp[b]) begin
        $error("amp band %0d expected %0d actual %0d", b, e.amp[b], a);
        fails++;
      end
      if (p !== e.ph[b]) begin
        $error("ph band %0d expected %0d actual %0d", b, $signed(e.ph[b]), $signed(p));
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumOut; b++) coef[b] = CoefReset[b];
      for (int c = 0; c < NumChannels; c++) begin
        pos[c] = 0;
        for (int b = 0; b < NumBands; b++) begin
          acc_i[c][b] = 0;
          acc_q[c][b] = 0;
        end
      end
      expected_q.delete();
      fails = 0;
      seen = 0;
    end else begin
      if (cfg_we_i && int'(cfg_idx_i) < NumOut) coef[cfg_idx_i] = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        demodulate(s_axis_tdata[ChanW-1:0], s_axis_tdata[ChanW +: SampleW]);
    end
  end

  final begin
    if (expected_q.size() != 0) $error("%0d results never arrived", expected_q.size());
  end
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mld_pkg::*;

  localparam int CycleLimit = 1200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CoefW-1:0]    cfg_data_i = '0;
  int                  fail_count, pending, results_seen;
  int                  cycles = 0;
  int                  send_idle = 0;
  int                  recv_idle = 0;
  int                  requests = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multiband_lockin_demodulator u_top (.*);

  mld_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls independently of the sender.
  always @(posedge clk_i) begin
    m_axis_tready <= (rst_ni && $urandom_range(99) >= recv_idle);
  end

  // The block stays busy after each request is taken, so the idle wait at the end of this task
  // costs nothing.
  task automatic send_sample(logic [ChanW-1:0] ch, logic [SampleW-1:0] smp);
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InW'({smp, ch});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    requests++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_coef(int idx, logic [CoefW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgIdxW'(idx);
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small samples so the filters stay in range; full-scale now and then.
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return SampleW'($urandom);
      default: return SampleW'($signed($urandom_range(20000)) - 10000);
    endcase
  endfunction

  initial begin
    logic [CoefW-1:0] cfg_sets [4][5];
    cfg_sets = '{
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd65535, 16'd65503, 16'd65535, 16'd65503, 16'd65535},
      '{16'd32768, 16'd1, 16'd50000, 16'd20000, 16'd65000},
      '{16'd60776, 16'd60776, 16'd60776, 16'd50972, 16'd39644}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero sample (zero vector phase), every channel.
    send_idle = 0;
    recv_idle = 0;
    send_sample(3'd0, 24'd0);
    send_sample(3'd0, 24'h7FFFFF);
    send_sample(3'd0, 24'h800000);
    send_sample(3'd7, 24'h800000);
    send_sample(3'd7, 24'h7FFFFF);
    for (int c = 0; c < NumChannels; c++) send_sample(3'(c), 24'hFFFFFF ^ 24'(c * 1111));
    send_sample(3'd1, 24'h555555);
    send_sample(3'd1, 24'hAAAAAA);
    drain();

    // Unknown register indexes must be ignored.
    write_coef(5, 16'hFFFF);
    write_coef(7, 16'h0000);

    for (int phase = 0; phase < 4; phase++) begin
      for (int r = 0; r < 5; r++) write_coef(r, cfg_sets[phase][r]);
      send_idle = (phase == 0) ? 14 : (phase == 1) ? 84 : 0;
      recv_idle = (phase == 0) ? 84 : (phase == 1) ? 14 : 0;
      for (int i = 0; i < 120; i++) begin
        // Drive one channel only for the first half of the last phase.
        if (phase == 3 && i < 60) send_sample(3'd2, pick_sample());
        else send_sample(3'($urandom_range(7)), pick_sample());
        if (i == 60) while (pending != 0) @(posedge clk_i);
      end
      drain();
    end

    $display("Sent %0d samples over four coefficient sets, checked %0d results.",
             requests, results_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
